FILE: rtl/s7_response_frame_checker_top_defines.svh
// ----------------------------------------------------------------------------
// S7 response frame checker: assertion macros
// Shared assertion helpers, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef S7_RESPONSE_FRAME_CHECKER_TOP_DEFINES_SVH
`define S7_RESPONSE_FRAME_CHECKER_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
// A property that must hold at every clock edge.
`define S7FC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// A condition that forces an expression in the following cycle.
`define S7FC_ASSERT_NEXT(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error(msg);
`else
`define S7FC_ASSERT(label, prop, msg)
`define S7FC_ASSERT_NEXT(label, cond, expr, msg)
`endif
`endif

FILE: rtl/s7fc_pkg.sv
// ----------------------------------------------------------------------------
// S7 response frame checker package
// Verdict codes, register indexes, reset values and the frame summary record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package s7fc_pkg;

	// Verdict codes; among failures the lowest code wins.
	typedef enum logic [3:0] {
		ST_OK       = 4'd0,
		ST_SHORT    = 4'd1,
		ST_VERSION  = 4'd2,
		ST_LENGTH   = 4'd3,
		ST_TOO_LONG = 4'd4,
		ST_COTP     = 4'd5,
		ST_PDU_TYPE = 4'd6,
		ST_PROTO    = 4'd7,
		ST_ROSCTR   = 4'd8,
		ST_ERROR    = 4'd9,
		ST_MAGIC    = 4'd10,
		ST_CRC      = 4'd11
	} status_t;

	// Configuration register indexes.
	localparam logic CFG_MAX_PAYLOAD = 1'b0;
	localparam logic CFG_MAGIC_WORD  = 1'b1;

	// Register reset values.
	localparam logic [15:0] RST_MAX_PAYLOAD = 16'd480;
	localparam logic [31:0] RST_MAGIC_WORD  = 32'hBAAD_F00D;

	// Default depth of the queue between front and back.
	localparam int QUEUE_DEPTH_DEF = 2;

	// Everything the verdict needs, captured on the final byte.
	typedef struct packed {
		logic [16:0] len;
		logic [7:0]  first_hdr;
		logic [15:0] declared_len;
		logic [15:0] cotp_hdr;
		logic [15:0] proto_rosctr;
		logic [15:0] ref_bytes;
		logic [15:0] err_bytes;
		logic        magic_seen;
		logic [15:0] crc_acc;
		logic [15:0] rx_crc;
	} summary_t;

endpackage
`default_nettype wire

FILE: rtl/s7fc_front.sv
// ----------------------------------------------------------------------------
// S7 response frame checker: front end
// Takes one byte a beat, latches header bytes, runs the CRC and the magic
// word scan, and queues a frame summary on the final byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "s7_response_frame_checker_top_defines.svh"
module s7fc_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire  [7:0]          rx_byte,
	input  wire                 last_byte,
	input  wire  [31:0]         magic_word,
	output logic                push,
	output s7fc_pkg::summary_t  push_data,
	input  wire                 push_ready
);
	import s7fc_pkg::*;

	localparam logic [16:0] IDX_VER    = 17'd0;
	localparam logic [16:0] IDX_LEN_HI = 17'd2;
	localparam logic [16:0] IDX_LEN_LO = 17'd3;
	localparam logic [16:0] IDX_COTP_H = 17'd4;
	localparam logic [16:0] IDX_COTP_L = 17'd5;
	localparam logic [16:0] IDX_PROTO  = 17'd11;
	localparam logic [16:0] IDX_ROSCTR = 17'd12;
	localparam logic [16:0] IDX_REF_HI = 17'd13;
	localparam logic [16:0] IDX_REF_LO = 17'd14;
	localparam logic [16:0] IDX_ERR_HI = 17'd19;
	localparam logic [16:0] IDX_ERR_LO = 17'd20;
	localparam logic [15:0] CRC_POLY   = 16'hA001;
	localparam logic [15:0] CRC_INIT   = 16'hFFFF;

	// Reflected CRC-16 over one byte, eight shift steps.
	function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	logic [16:0] cnt_q, cnt_d;
	logic [15:0] crc_q, crc_d;
	logic [23:0] recent_q;
	logic        magic_q, magic_d;
	logic [7:0]  first_q, first_d;
	logic [15:0] decl_q, decl_d;
	logic [15:0] cotp_q, cotp_d;
	logic [15:0] proto_q, proto_d;
	logic [15:0] ref_q, ref_d;
	logic [15:0] err_q, err_d;
	logic [31:0] window;
	logic        accept;

	assign in_ready = push_ready;
	assign accept   = in_valid && in_ready;
	assign window   = {recent_q, rx_byte};

	// Next frame state for the byte on the input.
	always_comb begin
		cnt_d   = cnt_q[16] ? cnt_q : cnt_q + 17'd1;
		crc_d   = (cnt_q >= IDX_LEN_HI) ? crc_feed(crc_q, recent_q[15:8]) : crc_q;
		magic_d = magic_q || ((cnt_q >= IDX_LEN_LO) && (window == magic_word));
		first_d = (cnt_q == IDX_VER) ? rx_byte : first_q;
		decl_d  = decl_q;
		cotp_d  = cotp_q;
		proto_d = proto_q;
		ref_d   = ref_q;
		err_d   = err_q;
		if (cnt_q == IDX_LEN_HI) decl_d[15:8]  = rx_byte;
		if (cnt_q == IDX_LEN_LO) decl_d[7:0]   = rx_byte;
		if (cnt_q == IDX_COTP_H) cotp_d[15:8]  = rx_byte;
		if (cnt_q == IDX_COTP_L) cotp_d[7:0]   = rx_byte;
		if (cnt_q == IDX_PROTO)  proto_d[15:8] = rx_byte;
		if (cnt_q == IDX_ROSCTR) proto_d[7:0]  = rx_byte;
		if (cnt_q == IDX_REF_HI) ref_d[15:8]   = rx_byte;
		if (cnt_q == IDX_REF_LO) ref_d[7:0]    = rx_byte;
		if (cnt_q == IDX_ERR_HI) err_d[15:8]   = rx_byte;
		if (cnt_q == IDX_ERR_LO) err_d[7:0]    = rx_byte;
	end

	// Summary queued on the final beat of a frame.
	always_comb begin
		push                   = accept && last_byte;
		push_data.len          = cnt_d;
		push_data.first_hdr    = first_d;
		push_data.declared_len = decl_d;
		push_data.cotp_hdr     = cotp_d;
		push_data.proto_rosctr = proto_d;
		push_data.ref_bytes    = ref_d;
		push_data.err_bytes    = err_d;
		push_data.magic_seen   = magic_d;
		push_data.crc_acc      = crc_d;
		push_data.rx_crc       = {rx_byte, recent_q[7:0]};
	end

	// Frame state; cleared after the final byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			crc_q    <= CRC_INIT;
			recent_q <= '0;
			magic_q  <= 1'b0;
			first_q  <= '0;
			decl_q   <= '0;
			cotp_q   <= '0;
			proto_q  <= '0;
			ref_q    <= '0;
			err_q    <= '0;
		end else if (accept) begin
			if (last_byte) begin
				cnt_q    <= '0;
				crc_q    <= CRC_INIT;
				recent_q <= '0;
				magic_q  <= 1'b0;
				first_q  <= '0;
				decl_q   <= '0;
				cotp_q   <= '0;
				proto_q  <= '0;
				ref_q    <= '0;
				err_q    <= '0;
			end else begin
				cnt_q    <= cnt_d;
				crc_q    <= crc_d;
				recent_q <= window[23:0];
				magic_q  <= magic_d;
				first_q  <= first_d;
				decl_q   <= decl_d;
				cotp_q   <= cotp_d;
				proto_q  <= proto_d;
				ref_q    <= ref_d;
				err_q    <= err_d;
			end
		end
	end

	`S7FC_ASSERT_NEXT(a_front_clear, accept && last_byte, cnt_q == '0 && crc_q == CRC_INIT, "frame state not cleared after final byte")
	`S7FC_ASSERT(a_front_sat, !cnt_q[16] || cnt_q[15:0] == '0, "byte count passed saturation")

endmodule
`default_nettype wire

FILE: rtl/s7fc_queue.sv
// ----------------------------------------------------------------------------
// S7 response frame checker: summary queue
// Small first-in first-out store of frame summaries between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "s7_response_frame_checker_top_defines.svh"
module s7fc_queue #(
	parameter int DEPTH = s7fc_pkg::QUEUE_DEPTH_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  s7fc_pkg::summary_t  push_data,
	output logic                push_ready,
	output logic                pop_valid,
	output s7fc_pkg::summary_t  pop_data,
	input  wire                 pop
);
	import s7fc_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	summary_t         mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem[rd_ptr_q];
	assign do_pop     = pop && pop_valid;

	// Storage, no reset needed.
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`S7FC_ASSERT(a_queue_bound, count_q <= CNT_W'(DEPTH), "queue fill count above depth")
	`S7FC_ASSERT(a_queue_ovf, !(push && !push_ready), "push into a full queue")
	`S7FC_ASSERT_NEXT(a_queue_grow, push && !do_pop, count_q == $past(count_q) + 1'b1, "fill count did not grow on push")

endmodule
`default_nettype wire

FILE: rtl/s7fc_back.sv
// ----------------------------------------------------------------------------
// S7 response frame checker: back end
// Turns a frame summary into a verdict and holds it in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "s7_response_frame_checker_top_defines.svh"
module s7fc_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 pop_valid,
	input  s7fc_pkg::summary_t  pop_data,
	output logic                pop,
	input  wire  [15:0]         max_payload_len,
	output logic                out_valid,
	input  wire                 out_ready,
	output logic [3:0]          status,
	output logic [15:0]         next_ref,
	output logic                ref_valid
);
	import s7fc_pkg::*;

	localparam logic [16:0] LEN_HDR   = 17'd4;
	localparam logic [16:0] LEN_COTP  = 17'd11;
	localparam logic [16:0] LEN_S7    = 17'd23;
	localparam logic [16:0] LEN_CRC   = 17'd6;
	localparam logic [16:0] LEN_REF   = 17'd15;
	localparam logic [7:0]  TPKT_VER  = 8'h03;
	localparam logic [7:0]  COTP_LEN  = 8'h11;
	localparam logic [7:0]  PDU_DT    = 8'hF0;
	localparam logic [7:0]  PDU_CC    = 8'hD0;
	localparam logic [7:0]  PDU_DR    = 8'h80;
	localparam logic [7:0]  S7_PROTO  = 8'h32;
	localparam logic [7:0]  ROSCTR_AD = 8'h03;
	localparam logic [7:0]  ROSCTR_UD = 8'h07;

	status_t     st;
	logic        ref_ok;
	logic [16:0] len_limit;
	logic [7:0]  pdu, rosctr;
	logic        out_valid_q, ref_valid_q;
	status_t     status_q;
	logic [15:0] next_ref_q;

	assign len_limit = {1'b0, max_payload_len} + LEN_HDR;
	assign pdu       = pop_data.cotp_hdr[7:0];
	assign rosctr    = pop_data.proto_rosctr[7:0];

	// Fixed-priority verdict.
	always_comb begin
		priority if (pop_data.len < LEN_HDR)                        st = ST_SHORT;
		else if (pop_data.first_hdr != TPKT_VER)                    st = ST_VERSION;
		else if (pop_data.len != {1'b0, pop_data.declared_len})     st = ST_LENGTH;
		else if (pop_data.len > len_limit)                          st = ST_TOO_LONG;
		else if (pop_data.len >= LEN_COTP &&
			pop_data.cotp_hdr[15:8] != COTP_LEN)                    st = ST_COTP;
		else if (pop_data.len >= LEN_COTP && pdu != PDU_DT &&
			pdu != PDU_CC && pdu != PDU_DR)                         st = ST_PDU_TYPE;
		else if (pop_data.len >= LEN_S7 &&
			pop_data.proto_rosctr[15:8] != S7_PROTO)                st = ST_PROTO;
		else if (pop_data.len >= LEN_S7 &&
			(rosctr == ROSCTR_AD || rosctr == ROSCTR_UD))           st = ST_ROSCTR;
		else if (pop_data.len >= LEN_S7 && pop_data.err_bytes != '0) st = ST_ERROR;
		else if (pop_data.magic_seen)                               st = ST_MAGIC;
		else if (pop_data.len >= LEN_CRC &&
			pop_data.crc_acc != pop_data.rx_crc)                    st = ST_CRC;
		else                                                        st = ST_OK;
		ref_ok = (st == ST_OK) && (pop_data.len >= LEN_REF);
	end

	// Take a summary whenever the output register is free or being emptied.
	assign pop = pop_valid && (!out_valid_q || out_ready);

	// Output register, control part.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= pop_valid;
		end
	end

	// Output register, payload part.
	always_ff @(posedge clk) begin
		if (pop) begin
			status_q    <= st;
			ref_valid_q <= ref_ok;
			next_ref_q  <= ref_ok ? pop_data.ref_bytes : 16'h0000;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign next_ref  = next_ref_q;
	assign ref_valid = ref_valid_q;

	`S7FC_ASSERT(a_back_refok, !(out_valid_q && ref_valid_q) || status_q == ST_OK, "reference given with a failing verdict")
	`S7FC_ASSERT(a_back_refzero, !(out_valid_q && !ref_valid_q) || next_ref_q == '0, "reference nonzero without ref_valid")

endmodule
`default_nettype wire

FILE: rtl/s7_response_frame_checker_top.sv
// ----------------------------------------------------------------------------
// S7 response frame checker: top level
// Checks TPKT/COTP/S7 response frames streamed one byte a beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one frame byte per beat on rx_byte,
//   last_byte high on the final beat of a frame. Every byte is taken at one
//   beat per cycle; in_ready drops only while the verdict queue is full.
//   Output channel (out_valid/out_ready): one verdict per frame, with status,
//   next_ref and ref_valid. After the final byte is accepted, the summary is
//   registered in the summary queue and the verdict then in the output
//   register. Frames follow each other with no gap; the CRC update of one
//   byte sits in the front end, between the byte count and the queue.
//   A stalled receiver holds the verdict in the output register; the queue
//   (QUEUE_DEPTH summaries) fills behind it, and only then does in_ready fall.
//   Configuration: cfg_we writes cfg_data into register cfg_index
//   (0 max_payload_len, 1 magic_word) at once; write only while idle.
//   Reset: arst_n clears frame state, the queue and the output valid flag and
//   loads max_payload_len 480 and magic_word 0xBAADF00D; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module s7_response_frame_checker_top #(
	parameter int QUEUE_DEPTH = s7fc_pkg::QUEUE_DEPTH_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [7:0]  rx_byte,
	input  wire         last_byte,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [3:0]  status,
	output logic [15:0] next_ref,
	output logic        ref_valid,
	input  wire         cfg_we,
	input  wire         cfg_index,
	input  wire  [31:0] cfg_data
);
	import s7fc_pkg::*;

	logic [15:0] max_payload_q;
	logic [31:0] magic_word_q;
	logic        push, push_ready, pop_valid, pop;
	summary_t    push_data, pop_data;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= RST_MAX_PAYLOAD;
			magic_word_q  <= RST_MAGIC_WORD;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MAX_PAYLOAD: max_payload_q <= cfg_data[15:0];
				CFG_MAGIC_WORD:  magic_word_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Front end: byte intake and per-frame accumulation.
	s7fc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.rx_byte    (rx_byte),
		.last_byte  (last_byte),
		.magic_word (magic_word_q),
		.push       (push),
		.push_data  (push_data),
		.push_ready (push_ready)
	);

	// Queue of frame summaries.
	s7fc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_data   (pop_data),
		.pop        (pop)
	);

	// Back end: verdict and output register.
	s7fc_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.pop_valid       (pop_valid),
		.pop_data        (pop_data),
		.pop             (pop),
		.max_payload_len (max_payload_q),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.status          (status),
		.next_ref        (next_ref),
		.ref_valid       (ref_valid)
	);

endmodule
`default_nettype wire

FILE: sim/s7fc_verdict_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// S7 response frame checker: verdict scoreboard
// Watches the byte, verdict and register channels of the frame checker. It
// keeps its own copy of the frame state, works out the verdict that each
// marked final byte must produce, and compares every verdict beat against it.
// ----------------------------------------------------------------------------

// Protocol constants and the CRC step, shared by the scoreboard and stimulus.
package s7fc_tb_pkg;

	localparam logic [7:0] TPKT_VERSION     = 8'h03;
	localparam logic [7:0] COTP_HDR_LEN     = 8'h11;
	localparam logic [7:0] PDU_DT_DATA      = 8'hF0;
	localparam logic [7:0] PDU_CONN_CONFIRM = 8'hD0;
	localparam logic [7:0] PDU_DISC_REQUEST = 8'h80;
	localparam logic [7:0] S7_PROTO_ID      = 8'h32;
	localparam logic [7:0] ROSCTR_ACK_DATA  = 8'h03;
	localparam logic [7:0] ROSCTR_USERDATA  = 8'h07;
	localparam logic [15:0] CRC_POLY        = 16'hA001;
	localparam logic [15:0] CRC_INIT        = 16'hFFFF;

	// One byte through the reflected CRC-16.
	function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++)
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		return c;
	endfunction

endpackage

module s7fc_verdict_checker (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	input  wire         in_ready,
	input  wire  [7:0]  rx_byte,
	input  wire         last_byte,
	input  wire         out_valid,
	input  wire         out_ready,
	input  wire  [3:0]  status,
	input  wire  [15:0] next_ref,
	input  wire         ref_valid,
	input  wire         cfg_we,
	input  wire         cfg_index,
	input  wire  [31:0] cfg_data,
	output int          fail_count,
	output int          due_count
);
	import s7fc_pkg::*;
	import s7fc_tb_pkg::*;

	typedef struct packed {
		status_t     st;
		logic [15:0] ref_num;
		logic        ref_ok;
	} verdict_t;

	verdict_t verdicts_due[$];

	// Register copies.
	logic [15:0] lim_payload;
	logic [31:0] magic_pat;

	// Frame state, as the block holds it.
	logic [16:0] frame_len;
	logic [15:0] crc_run;
	logic [23:0] tail_bytes;
	logic        magic_hit;
	logic [7:0]  hdr_version;
	logic [15:0] decl_len;
	logic [15:0] cotp_pair;
	logic [15:0] proto_pair;
	logic [15:0] ref_pair;
	logic [15:0] err_pair;

	task automatic clear_frame();
		frame_len   = '0;
		crc_run     = CRC_INIT;
		tail_bytes  = '0;
		magic_hit   = 1'b0;
		hdr_version = '0;
		decl_len    = '0;
		cotp_pair   = '0;
		proto_pair  = '0;
		ref_pair    = '0;
		err_pair    = '0;
	endtask

	// Take one accepted byte; on the final byte, queue the verdict.
	task automatic advance_frame(input logic [7:0] b, input logic fin);
		logic [16:0] idx;
		logic [31:0] win;
		logic [15:0] crc_rx;
		logic [16:0] n;
		status_t     st;
		verdict_t    v;
		idx = frame_len;
		case (idx)
			17'd0:  hdr_version      = b;
			17'd2:  decl_len[15:8]   = b;
			17'd3:  decl_len[7:0]    = b;
			17'd4:  cotp_pair[15:8]  = b;
			17'd5:  cotp_pair[7:0]   = b;
			17'd11: proto_pair[15:8] = b;
			17'd12: proto_pair[7:0]  = b;
			17'd13: ref_pair[15:8]   = b;
			17'd14: ref_pair[7:0]    = b;
			17'd19: err_pair[15:8]   = b;
			17'd20: err_pair[7:0]    = b;
			default: ;
		endcase

		// The CRC trails the stream by two bytes, so the trailer is never fed.
		if (idx >= 17'd2)
			crc_run = crc16_feed(crc_run, tail_bytes[15:8]);
		win = {tail_bytes, b};
		if (idx >= 17'd3 && win == magic_pat)
			magic_hit = 1'b1;
		crc_rx     = {b, tail_bytes[7:0]};
		tail_bytes = win[23:0];
		frame_len  = (idx < 17'h10000) ? idx + 17'd1 : 17'h10000;

		if (fin) begin
			n = frame_len;
			// Fixed priority: the first condition that holds gives the verdict.
			if (n < 17'd4)
				st = ST_SHORT;
			else if (hdr_version != TPKT_VERSION)
				st = ST_VERSION;
			else if (n != {1'b0, decl_len})
				st = ST_LENGTH;
			else if (n > {1'b0, lim_payload} + 17'd4)
				st = ST_TOO_LONG;
			else if (n >= 17'd11 && cotp_pair[15:8] != COTP_HDR_LEN)
				st = ST_COTP;
			else if (n >= 17'd11 && cotp_pair[7:0] != PDU_DT_DATA &&
					cotp_pair[7:0] != PDU_CONN_CONFIRM && cotp_pair[7:0] != PDU_DISC_REQUEST)
				st = ST_PDU_TYPE;
			else if (n >= 17'd23 && proto_pair[15:8] != S7_PROTO_ID)
				st = ST_PROTO;
			else if (n >= 17'd23 &&
					(proto_pair[7:0] == ROSCTR_ACK_DATA || proto_pair[7:0] == ROSCTR_USERDATA))
				st = ST_ROSCTR;
			else if (n >= 17'd23 && err_pair != 16'h0000)
				st = ST_ERROR;
			else if (magic_hit)
				st = ST_MAGIC;
			else if (n >= 17'd6 && crc_run != crc_rx)
				st = ST_CRC;
			else
				st = ST_OK;
			v.st      = st;
			v.ref_ok  = (st == ST_OK) && (n >= 17'd15);
			v.ref_num = v.ref_ok ? ref_pair : 16'h0000;
			verdicts_due.push_back(v);
			clear_frame();
		end
	endtask

	// Compare one verdict beat with the oldest expectation.
	task automatic check_verdict();
		verdict_t v;
		if (verdicts_due.size() == 0) begin
			$error("verdict beat with no frame outstanding: status %0d", status);
			fail_count++;
		end else begin
			v = verdicts_due.pop_front();
			if (status !== v.st) begin
				$error("status: expected %0d, got %0d", v.st, status);
				fail_count++;
			end
			if (next_ref !== v.ref_num) begin
				$error("next_ref: expected 0x%04h, got 0x%04h", v.ref_num, next_ref);
				fail_count++;
			end
			if (ref_valid !== v.ref_ok) begin
				$error("ref_valid: expected %0d, got %0d", v.ref_ok, ref_valid);
				fail_count++;
			end
		end
	endtask

	// Sample all three channels at the clock edge; bytes are predicted before
	// verdicts are checked.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			verdicts_due.delete();
			lim_payload = RST_MAX_PAYLOAD;
			magic_pat   = RST_MAGIC_WORD;
			clear_frame();
			fail_count  = 0;
			due_count   = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_MAX_PAYLOAD)
					lim_payload = cfg_data[15:0];
				else
					magic_pat = cfg_data;
			end
			if (in_valid && in_ready)
				advance_frame(rx_byte, last_byte);
			if (out_valid && out_ready)
				check_verdict();
			due_count = verdicts_due.size();
		end
	end

endmodule

FILE: sim/tb_s7_response_frame_checker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// S7 response frame checker: testbench top
// Streams directed and random TPKT/COTP/S7 frames into the checker, with
// random bursts and gaps on the byte side and a changing stall pattern on the
// verdict side, reprogramming both registers between phases. The scoreboard
// beside the block does the predicting; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_s7_response_frame_checker_top;
	import s7fc_pkg::*;
	import s7fc_tb_pkg::*;

	localparam int QUIET_LIMIT  = 5000;
	localparam int RANDOM_BYTES = 400;

	typedef enum int {
		FLT_NONE, FLT_VERSION, FLT_LENGTH, FLT_COTP, FLT_PDU, FLT_PROTO,
		FLT_ROSCTR, FLT_ERR, FLT_MAGIC, FLT_CRC, FLT_NOISE
	} fault_t;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic [7:0]  rx_byte   = 8'h00;
	logic        last_byte = 1'b0;
	logic        out_ready = 1'b0;
	logic        cfg_we    = 1'b0;
	logic        cfg_index = 1'b0;
	logic [31:0] cfg_data  = 32'h0;
	wire         in_ready;
	wire         out_valid;
	wire  [3:0]  status;
	wire  [15:0] next_ref;
	wire         ref_valid;
	int          fail_count;
	int          due_count;

	logic [7:0]  frame_buf[$];
	logic [15:0] cur_lim   = RST_MAX_PAYLOAD;
	logic [31:0] cur_magic = RST_MAGIC_WORD;
	int          burst_left = 0;
	int          quiet_cycles = 0;
	logic [7:0]  ready_mask = 8'hFF;
	logic [15:0] stall_tick = '0;

	s7_response_frame_checker_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.rx_byte   (rx_byte),
		.last_byte (last_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.next_ref  (next_ref),
		.ref_valid (ref_valid),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	s7fc_verdict_checker scoreboard (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.rx_byte    (rx_byte),
		.last_byte  (last_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.next_ref   (next_ref),
		.ref_valid  (ref_valid),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.due_count  (due_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Receiver stalls follow an eight-bit mask, redrawn whenever stall_tick[6:0] is zero;
	// half the masks never stall.
	always @(posedge clk) begin
		logic [7:0] m;
		stall_tick <= stall_tick + 16'd1;
		if (stall_tick[6:0] == 7'd0) begin
			case ($urandom_range(0, 3))
				0, 1:    m = 8'hFF;
				2:       m = 8'($urandom);
				default: m = 8'h11 << $urandom_range(0, 3);
			endcase
			if (m == 8'h00)
				m = 8'h01;
			ready_mask <= m;
		end
		out_ready <= ready_mask[stall_tick[2:0]];
	end

	// Watchdog: too long without a beat on either channel ends the run.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic logic [7:0] nonzero_byte();
		return 8'($urandom_range(1, 255));
	endfunction

	task automatic set_at(input int i, input logic [7:0] v);
		if (i < frame_buf.size())
			frame_buf[i] = v;
	endtask

	// Trailer: CRC over all but the last two bytes, low byte first.
	task automatic seal_crc();
		logic [15:0] c;
		int n;
		n = frame_buf.size();
		if (n >= 6) begin
			c = CRC_INIT;
			for (int i = 0; i < n - 2; i++)
				c = crc16_feed(c, frame_buf[i]);
			frame_buf[n - 2] = c[7:0];
			frame_buf[n - 1] = c[15:8];
		end
	endtask

	task automatic put_magic(input int pos);
		for (int k = 0; k < 4; k++)
			set_at(pos + k, cur_magic[31 - 8 * k -: 8]);
	endtask

	// Frame of n bytes with random content, well formed unless f is FLT_NOISE, then fault f.
	task automatic make_frame(input int n, input fault_t f);
		frame_buf.delete();
		repeat (n) frame_buf.push_back(8'($urandom));
		if (f != FLT_NOISE) begin
			set_at(0, TPKT_VERSION);
			set_at(2, n[15:8]);
			set_at(3, n[7:0]);
			set_at(4, COTP_HDR_LEN);
			case ($urandom_range(0, 2))
				0:       set_at(5, PDU_DT_DATA);
				1:       set_at(5, PDU_CONN_CONFIRM);
				default: set_at(5, PDU_DISC_REQUEST);
			endcase
			set_at(11, S7_PROTO_ID);
			if (n > 12 && (frame_buf[12] == ROSCTR_ACK_DATA || frame_buf[12] == ROSCTR_USERDATA))
				frame_buf[12] = 8'h01;
			set_at(19, 8'h00);
			set_at(20, 8'h00);
			case (f)
				FLT_VERSION: set_at(0, TPKT_VERSION ^ nonzero_byte());
				FLT_LENGTH:  set_at($urandom_range(2, 3), nonzero_byte() ^ n[7:0]);
				FLT_COTP:    set_at(4, COTP_HDR_LEN ^ nonzero_byte());
				FLT_PDU:     set_at(5, 8'($urandom));
				FLT_PROTO:   set_at(11, S7_PROTO_ID ^ nonzero_byte());
				FLT_ROSCTR:  set_at(12, $urandom_range(0, 1) ? ROSCTR_ACK_DATA : ROSCTR_USERDATA);
				FLT_ERR:     set_at($urandom_range(19, 20), nonzero_byte());
				default: ;
			endcase
			seal_crc();
		end
		if (f == FLT_MAGIC && n >= 4)
			put_magic($urandom_range(0, 1) ? n - 4 : $urandom_range(0, n - 4));
		if (f == FLT_CRC && n >= 6)
			frame_buf[n - 1 - $urandom_range(0, 1)] ^= nonzero_byte();
	endtask

	// One byte beat. Called and returning at a rising edge; bursts of random
	// length are separated by random gaps.
	task automatic push_byte(input logic [7:0] b, input logic fin);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
				: $urandom_range(1, 24);
			gap = $urandom_range(0, 5);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid  <= 1'b1;
		rx_byte   <= b;
		last_byte <= fin;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		burst_left--;
	endtask

	task automatic send_frame();
		foreach (frame_buf[i])
			push_byte(frame_buf[i], i == frame_buf.size() - 1);
	endtask

	// Hold the sender until every verdict is in, then let the pipe drain.
	task automatic drain();
		in_valid   <= 1'b0;
		burst_left = 0;
		do @(negedge clk); while (due_count != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_regs(input logic [15:0] lim, input logic [31:0] magic);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= CFG_MAX_PAYLOAD;
		cfg_data  <= {16'h0000, lim};
		@(posedge clk);
		cfg_index <= CFG_MAGIC_WORD;
		cfg_data  <= magic;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cur_lim   = lim;
		cur_magic = magic;
	endtask

	task automatic frame(input int n, input fault_t f);
		make_frame(n, f);
		send_frame();
	endtask

	initial begin
		int sent;
		int phase_at;
		int phase;
		int n;
		fault_t f;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames under the reset register values.
		frame(1, FLT_NONE);
		frame(3, FLT_NONE);
		frame(4, FLT_NONE);
		frame(5, FLT_NONE);
		frame(6, FLT_NONE);
		frame(14, FLT_NONE);
		frame(15, FLT_NONE);
		frame(23, FLT_NONE);
		frame(20, FLT_VERSION);
		frame(20, FLT_LENGTH);
		frame(11, FLT_COTP);
		frame(11, FLT_PDU);
		frame(23, FLT_PROTO);
		make_frame(23, FLT_NONE);
		set_at(12, ROSCTR_ACK_DATA);
		seal_crc();
		send_frame();
		make_frame(23, FLT_NONE);
		set_at(12, ROSCTR_USERDATA);
		seal_crc();
		send_frame();
		make_frame(24, FLT_NONE);
		set_at(19, nonzero_byte());
		seal_crc();
		send_frame();
		make_frame(24, FLT_NONE);
		set_at(20, nonzero_byte());
		seal_crc();
		send_frame();
		// Magic word in mid-frame, then in the window ending on the final byte.
		make_frame(40, FLT_NONE);
		put_magic(21);
		seal_crc();
		send_frame();
		make_frame(40, FLT_NONE);
		put_magic(36);
		send_frame();
		frame(6, FLT_CRC);
		frame(484, FLT_NONE);
		frame(485, FLT_NONE);

		// Smallest payload limit: four bytes pass, five are too long.
		set_regs(16'h0000, RST_MAGIC_WORD);
		frame(4, FLT_NONE);
		frame(5, FLT_NONE);

		// Random frames, four register phases.
		sent = 0;
		phase_at = 0;
		phase = 0;
		while (sent < RANDOM_BYTES) begin
			if (sent >= phase_at) begin
				case (phase)
					0:       set_regs(16'h0000, 32'h0000_0000);
					1:       set_regs(16'hFFFF, 32'hFFFF_FFFF);
					2:       set_regs(16'($urandom_range(16, 296)), $urandom);
					default: set_regs(RST_MAX_PAYLOAD, $urandom);
				endcase
				phase++;
				phase_at += RANDOM_BYTES / 4;
			end
			case ($urandom_range(0, 19))
				0:       n = $urandom_range(1, 5);
				1, 2:    n = $urandom_range(41, 160);
				3:       n = (cur_lim <= 16'd295) ? cur_lim + 4 + $urandom_range(0, 1)
					: $urandom_range(23, 40);
				default: n = $urandom_range(4, 40);
			endcase
			f = $urandom_range(0, 1) ? FLT_NONE : fault_t'($urandom_range(1, 10));
			frame(n, f);
			sent += n;
			if ($urandom_range(0, 19) == 0)
				drain();
		end

		drain();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
